// ----- rtl/core/rcd_pkg.sv -----
package rcd_pkg;

    localparam int unsigned CHAN_W = 5;
    localparam int unsigned PATTERN_W = 32;

    localparam logic [CHAN_W-1:0] CH_ALL_OFF = 5'd25;
    localparam logic [CHAN_W-1:0] CH_MAX_RELAY = 5'd12;

    localparam logic [7:0] KEY_NONE = 8'hFE;
    localparam logic [7:0] KEY_ALL_OFF = 8'h04;

    localparam logic [7:0] CHAR_NUL = 8'h00;
    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_HASH = 8'h23;
    localparam logic [7:0] CHAR_STAR = 8'h2A;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_ONE = 8'h31;
    localparam logic [7:0] CHAR_TWO = 8'h32;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    localparam logic [7:0] RELAY_OFF = 8'h2A;
    localparam logic [7:0] RELAY_SEL_A = 8'h2C;
    localparam logic [7:0] RELAY_SEL_B = 8'h32;
    localparam logic [7:0] RELAY_SEL_C = 8'h4A;

    localparam logic [PATTERN_W-1:0] PATTERN_ALL_OFF =
        {RELAY_OFF, RELAY_OFF, RELAY_OFF, RELAY_OFF};

    // One pattern request handed from the decoder to the output stage
    typedef struct packed {
        logic              valid;    // at least one beat to send
        logic              two;      // all-off beat followed by channel beat
        logic [CHAN_W-1:0] channel;
    } rcd_job_t;

    typedef struct packed {
        logic ready;    // output stage can take a new job this cycle
        logic pend;     // channel beat still waiting behind the all-off beat
    } rcd_emit_status_t;

    // Number of beats an apply of the channel produces
    function automatic logic [1:0] apply_beats(input logic [CHAN_W-1:0] ch);
        logic [1:0] beats;
        beats = 2'd0;
        if (ch == CH_ALL_OFF)
            beats = 2'd1;
        else if (ch != '0 && ch <= CH_MAX_RELAY)
            beats = 2'd2;
        return beats;
    endfunction

    // Relay pattern of a channel, first shifted byte in the low bits
    function automatic logic [PATTERN_W-1:0] channel_pattern(input logic [CHAN_W-1:0] ch);
        logic [PATTERN_W-1:0] pat;
        case (ch)
            5'd1:    pat = {RELAY_OFF, RELAY_OFF, RELAY_OFF, RELAY_SEL_A};
            5'd2:    pat = {RELAY_OFF, RELAY_OFF, RELAY_OFF, RELAY_SEL_B};
            5'd3:    pat = {RELAY_OFF, RELAY_OFF, RELAY_OFF, RELAY_SEL_C};
            5'd4:    pat = {RELAY_OFF, RELAY_OFF, RELAY_SEL_A, RELAY_OFF};
            5'd5:    pat = {RELAY_OFF, RELAY_OFF, RELAY_SEL_B, RELAY_OFF};
            5'd6:    pat = {RELAY_OFF, RELAY_OFF, RELAY_SEL_C, RELAY_OFF};
            5'd7:    pat = {RELAY_OFF, RELAY_SEL_A, RELAY_OFF, RELAY_OFF};
            5'd8:    pat = {RELAY_OFF, RELAY_SEL_B, RELAY_OFF, RELAY_OFF};
            5'd9:    pat = {RELAY_OFF, RELAY_SEL_C, RELAY_OFF, RELAY_OFF};
            5'd10:   pat = {RELAY_SEL_A, RELAY_OFF, RELAY_OFF, RELAY_OFF};
            5'd11:   pat = {RELAY_SEL_B, RELAY_OFF, RELAY_OFF, RELAY_OFF};
            5'd12:   pat = {RELAY_SEL_C, RELAY_OFF, RELAY_OFF, RELAY_OFF};
            default: pat = PATTERN_ALL_OFF;
        endcase
        return pat;
    endfunction

endpackage

// ----- rtl/core/rcd_decode.sv -----
module rcd_decode #(
    parameter int unsigned LINE_LIMIT = 15
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          in_func,
    input  logic [7:0]                    in_data,
    input  rcd_pkg::rcd_emit_status_t     emit_status,
    output rcd_pkg::rcd_job_t             job
);

    localparam int unsigned CW = $clog2(LINE_LIMIT);

    logic                        valid_reg;
    logic                        func_reg;
    logic [7:0]                  data_reg;

    logic [CW-1:0]               count_reg, count_next;
    logic [7:0]                  first_reg, first_next;
    logic [7:0]                  second_reg, second_next;
    logic [7:0]                  prev_reg, prev_next;
    logic [rcd_pkg::CHAN_W-1:0]  chan_reg, chan_next;
    logic [7:0]                  key_reg, key_next;

    logic [CW:0]                 n;
    logic                        apply;
    logic [rcd_pkg::CHAN_W-1:0]  apply_ch;
    logic [rcd_pkg::CHAN_W-1:0]  key_ch;
    logic [rcd_pkg::CHAN_W-1:0]  pair_ch;
    logic [1:0]                  beats;
    logic                        take;

    // key code: row in bits 2:0, column in bits 7:3; channel = row*6 + col + 1
    assign key_ch = rcd_pkg::CHAN_W'({data_reg[1:0], 2'b00})
                  + rcd_pkg::CHAN_W'({data_reg[1:0], 1'b0})
                  + rcd_pkg::CHAN_W'(data_reg[5:3]) + rcd_pkg::CHAN_W'(1);

    // two-digit line: tens*10 + ones
    assign pair_ch = rcd_pkg::CHAN_W'({first_reg[1:0], 3'b000})
                   + rcd_pkg::CHAN_W'({first_reg[1:0], 1'b0})
                   + rcd_pkg::CHAN_W'(second_reg[3:0]);

    assign n = {1'b0, count_reg} + (CW+1)'(1);

    always_comb
    begin
        count_next  = count_reg;
        first_next  = first_reg;
        second_next = second_reg;
        prev_next   = prev_reg;
        chan_next   = chan_reg;
        key_next    = key_reg;
        apply       = 1'b0;
        apply_ch    = chan_reg;

        if (func_reg)
        begin
            if (data_reg != key_reg)
            begin
                key_next = data_reg;
                if (data_reg == rcd_pkg::KEY_ALL_OFF)
                begin
                    chan_next = rcd_pkg::CH_ALL_OFF;
                    apply     = 1'b1;
                    apply_ch  = rcd_pkg::CH_ALL_OFF;
                end
                else
                begin
                    // codes outside the key grid keep the current channel
                    if (!data_reg[2] && data_reg[7:3] <= 5'd5)
                    begin
                        chan_next = key_ch;
                        apply_ch  = key_ch;
                    end
                    apply = (apply_ch <= rcd_pkg::CH_MAX_RELAY);
                end
            end
        end
        else if (data_reg != rcd_pkg::CHAR_NUL)
        begin
            if (count_reg == '0)
                first_next = data_reg;
            else if (count_reg == CW'(1))
                second_next = data_reg;
            prev_next = data_reg;

            if (n >= (CW+1)'(LINE_LIMIT))
                count_next = '0;
            else if (data_reg != rcd_pkg::CHAR_LF)
                count_next = n[CW-1:0];
            else
            begin
                count_next = '0;
                if (n > (CW+1)'(2) && prev_reg == rcd_pkg::CHAR_CR)
                begin
                    if (n == (CW+1)'(3) && first_reg == rcd_pkg::CHAR_HASH)
                        apply = 1'b1;
                    else if (n == (CW+1)'(3) && first_reg == rcd_pkg::CHAR_STAR)
                    begin
                        chan_next = rcd_pkg::CH_ALL_OFF;
                        apply     = 1'b1;
                        apply_ch  = rcd_pkg::CH_ALL_OFF;
                    end
                    else if (n == (CW+1)'(4) && first_reg > rcd_pkg::CHAR_ZERO
                             && first_reg <= rcd_pkg::CHAR_NINE)
                    begin
                        chan_next = rcd_pkg::CHAN_W'(first_reg[3:0]);
                        apply     = 1'b1;
                        apply_ch  = rcd_pkg::CHAN_W'(first_reg[3:0]);
                    end
                    else if (n == (CW+1)'(5)
                             && second_reg >= rcd_pkg::CHAR_ZERO
                             && second_reg <= rcd_pkg::CHAR_NINE
                             && (first_reg == rcd_pkg::CHAR_ONE
                                 || first_reg == rcd_pkg::CHAR_TWO))
                    begin
                        chan_next = pair_ch;
                        apply_ch  = pair_ch;
                        apply     = (pair_ch <= rcd_pkg::CH_MAX_RELAY);
                    end
                end
            end
        end

        beats       = apply ? rcd_pkg::apply_beats(apply_ch) : 2'd0;
        job.valid   = valid_reg && (beats != 2'd0);
        job.two     = (beats == 2'd2);
        job.channel = apply_ch;
        // an item that causes no beat retires without waiting on the output
        take        = valid_reg && ((beats == 2'd0) || emit_status.ready);
    end

    assign in_ready = !valid_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            count_reg <= '0;
            chan_reg  <= rcd_pkg::CH_ALL_OFF;
            key_reg   <= rcd_pkg::KEY_NONE;
        end
        else
        begin
            if (in_ready)
                valid_reg <= in_valid;
            if (take)
            begin
                count_reg <= count_next;
                chan_reg  <= chan_next;
                key_reg   <= key_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            func_reg <= in_func;
            data_reg <= in_data;
        end
        if (take)
        begin
            first_reg  <= first_next;
            second_reg <= second_next;
            prev_reg   <= prev_next;
        end
    end

endmodule

// ----- rtl/core/rcd_emit.sv -----
module rcd_emit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  rcd_pkg::rcd_job_t                  job,
    output rcd_pkg::rcd_emit_status_t          emit_status,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [rcd_pkg::PATTERN_W-1:0]      out_data,
    output logic                               out_last
);

    logic                              valid_reg, valid_next;
    logic                              pend_reg, pend_next;
    logic [rcd_pkg::CHAN_W-1:0]        pend_ch_reg, pend_ch_next;
    logic [rcd_pkg::PATTERN_W-1:0]     data_reg, data_next;
    logic                              last_reg, last_next;
    logic                              out_free;

    assign out_free          = !valid_reg || out_ready;
    assign emit_status.ready = !pend_reg && out_free;
    assign emit_status.pend  = pend_reg;

    always_comb
    begin
        valid_next   = valid_reg;
        pend_next    = pend_reg;
        pend_ch_next = pend_ch_reg;
        data_next    = data_reg;
        last_next    = last_reg;
        if (out_free)
        begin
            if (pend_reg)
            begin
                // second beat: the channel pattern closes the run
                valid_next = 1'b1;
                pend_next  = 1'b0;
                data_next  = rcd_pkg::channel_pattern(pend_ch_reg);
                last_next  = 1'b1;
            end
            else if (job.valid)
            begin
                valid_next   = 1'b1;
                pend_next    = job.two;
                pend_ch_next = job.channel;
                data_next    = rcd_pkg::PATTERN_ALL_OFF;
                last_next    = !job.two;
            end
            else
                valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_ch_reg <= pend_ch_next;
        data_reg    <= data_next;
        last_reg    <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;
    assign out_last  = last_reg;

endmodule

// ----- rtl/core/relay_channel_command_decoder_core.sv -----
// A result beat passes through the input register and then the output register on its way to m_axis;
//   a channel apply's second beat enters the output register as the sink takes its first.
// Throughput: one input beat per cycle when no pattern results; otherwise an input beat
//   retires only when no channel beat is pending and the output register is free or being
//   taken, set by the single output register and its one pending-beat slot.
// Reset (rst_n low, asynchronous): line count 0, channel 25 (all off), no key seen.
module relay_channel_command_decoder_core #(
    parameter int unsigned LINE_LIMIT = 15
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data: serial character or key scan code
    input  logic        s_axis_tuser,   // [0] func: 0 serial byte, 1 key scan code

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] relay_byte_first, [15:8] relay_byte_second,
                                        // [23:16] relay_byte_third, [31:24] relay_byte_fourth
    output logic        m_axis_tlast    // last_of_run
);

    rcd_pkg::rcd_job_t          job;
    rcd_pkg::rcd_emit_status_t  emit_status;

    // Input register, line/key state and the decode of one beat.
    // State commits only when the beat retires, into the output stage if it sends a beat.
    rcd_decode #(
        .LINE_LIMIT (LINE_LIMIT)
    ) u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_func     (s_axis_tuser),
        .in_data     (s_axis_tdata),
        .emit_status (emit_status),
        .job         (job)
    );

    // Output register plus one pending slot: the all-off beat goes out first,
    // the channel pattern is held behind it until the sink takes the first beat.
    rcd_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .job         (job),
        .emit_status (emit_status),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_data    (m_axis_tdata),
        .out_last    (m_axis_tlast)
    );

    // A pending channel beat always sits behind a visible all-off beat.
    a_pend_has_beat: assert property (@(posedge clk) disable iff (!rst_n)
        emit_status.pend |-> m_axis_tvalid)
        else $error("pending channel beat without a beat on the output");

    // A beat that does not close its run is always followed by a pending beat.
    a_open_run_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> emit_status.pend)
        else $error("open run with no pending channel beat");

    // The opening beat of a two-beat run is the all-off pattern.
    a_open_run_all_off: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata == rcd_pkg::PATTERN_ALL_OFF))
        else $error("first beat of a channel apply is not all-off");

    // The output stage takes no new job while a channel beat is pending.
    a_no_job_while_pend: assert property (@(posedge clk) disable iff (!rst_n)
        emit_status.pend |-> !emit_status.ready)
        else $error("output stage ready while a beat is pending");

endmodule

// ----- tb/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LINE_LIMIT = 15;
    localparam int unsigned RANDOM_ITEMS = 900;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned NUM_DIRECTED = 24;
    localparam int unsigned DRAIN_EVERY = 150;
    localparam int unsigned IDLE_PCT = 28;

    localparam logic FUNC_SERIAL = 1'b0;
    localparam logic FUNC_KEY = 1'b1;

    localparam logic [rcd_pkg::PATTERN_W-1:0] OFF_PATTERN = {4{rcd_pkg::RELAY_OFF}};
    localparam logic [rcd_pkg::PATTERN_W-1:0] NO_PATTERN = '0;

    // One relay pattern beat as it leaves the block
    typedef struct packed {
        logic [rcd_pkg::PATTERN_W-1:0] pattern;
        logic                          last;
    } relay_beat_t;

    // One input beat; typed rows carry their own expected patterns
    typedef struct packed {
        logic                          typed;
        logic [1:0]                    n_beats;
        logic [rcd_pkg::PATTERN_W-1:0] pat0;
        logic [rcd_pkg::PATTERN_W-1:0] pat1;
        logic                          func;
        logic [7:0]                    data;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;     // [7:0] data
    logic        s_axis_tuser = 1'b0;   // [0] func
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // [7:0] first .. [31:24] fourth relay byte
    logic        m_axis_tlast;

    // Decoder state mirrored from the block
    logic [3:0]                 line_len = '0;
    logic [7:0]                 line_head = '0;
    logic [7:0]                 line_tail = '0;
    logic [7:0]                 last_char = '0;
    logic [rcd_pkg::CHAN_W-1:0] channel = rcd_pkg::CH_ALL_OFF;
    logic [7:0]                 last_key = rcd_pkg::KEY_NONE;

    relay_beat_t relay_run [$];         // beats caused by the current input beat
    relay_beat_t relay_beats_due [$];   // beats still owed by the block

    int unsigned items_taken = 0;
    int unsigned keys_taken = 0;
    int unsigned serial_taken = 0;
    int unsigned beats_checked = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    int unsigned idle_pct = IDLE_PCT;

    string byte_field [4] = '{"relay_byte_first", "relay_byte_second",
                              "relay_byte_third", "relay_byte_fourth"};

    // typed, n_beats, pat0, pat1, func, data
    stim_row_t directed_rows [NUM_DIRECTED] = '{
        // power-up key code repeated: ignored
        '{1'b1, 2'd0, NO_PATTERN, NO_PATTERN, FUNC_KEY, rcd_pkg::KEY_NONE},
        // zero serial byte: ignored
        '{1'b1, 2'd0, NO_PATTERN, NO_PATTERN, FUNC_SERIAL, rcd_pkg::CHAR_NUL},
        // '#' re-applies channel 25 after reset: all-off only
        '{1'b0, 2'd0, NO_PATTERN, NO_PATTERN, FUNC_SERIAL, rcd_pkg::CHAR_HASH},
        '{1'b0, 2'd0, NO_PATTERN, NO_PATTERN, FUNC_SERIAL, rcd_pkg::CHAR_CR},
        '{1'b1, 2'd1, OFF_PATTERN, NO_PATTERN, FUNC_SERIAL, rcd_pkg::CHAR_LF},
        // all-off key, then the same key again
        '{1'b1, 2'd1, OFF_PATTERN, NO_PATTERN, FUNC_KEY, rcd_pkg::KEY_ALL_OFF},
        '{1'b1, 2'd0, NO_PATTERN, NO_PATTERN, FUNC_KEY, rcd_pkg::KEY_ALL_OFF},
        // row 0 col 0 picks channel 1
        '{1'b0, 2'd0, NO_PATTERN, NO_PATTERN, FUNC_KEY, 8'h00},
        // off-table code keeps channel 1 and re-applies it
        '{1'b0, 2'd0, NO_PATTERN, NO_PATTERN, FUNC_KEY, 8'hFF},
        // row 3 col 5 picks channel 24: no relay to drive
        '{1'b0, 2'd0, NO_PATTERN, NO_PATTERN, FUNC_KEY, 8'h2B},
        // unknown "!" line is dropped
        '{1'b0, 2'd0, NO_PATTERN, NO_PATTERN, FUNC_SERIAL, 8'h21},
        '{1'b0, 2'd0, NO_PATTERN, NO_PATTERN, FUNC_SERIAL, rcd_pkg::CHAR_CR},
        '{1'b0, 2'd0, NO_PATTERN, NO_PATTERN, FUNC_SERIAL, rcd_pkg::CHAR_LF},
        // LF without CR is dropped
        '{1'b0, 2'd0, NO_PATTERN, NO_PATTERN, FUNC_SERIAL, rcd_pkg::CHAR_NINE},
        '{1'b0, 2'd0, NO_PATTERN, NO_PATTERN, FUNC_SERIAL, 8'hFF},
        '{1'b0, 2'd0, NO_PATTERN, NO_PATTERN, FUNC_SERIAL, rcd_pkg::CHAR_LF},
        // two digits plus filler: channel 12, top relay byte
        '{1'b0, 2'd0, NO_PATTERN, NO_PATTERN, FUNC_SERIAL, rcd_pkg::CHAR_ONE},
        '{1'b0, 2'd0, NO_PATTERN, NO_PATTERN, FUNC_SERIAL, rcd_pkg::CHAR_TWO},
        '{1'b0, 2'd0, NO_PATTERN, NO_PATTERN, FUNC_SERIAL, 8'h80},
        '{1'b0, 2'd0, NO_PATTERN, NO_PATTERN, FUNC_SERIAL, rcd_pkg::CHAR_CR},
        '{1'b0, 2'd0, NO_PATTERN, NO_PATTERN, FUNC_SERIAL, rcd_pkg::CHAR_LF},
        // '*' turns everything off
        '{1'b0, 2'd0, NO_PATTERN, NO_PATTERN, FUNC_SERIAL, rcd_pkg::CHAR_STAR},
        '{1'b0, 2'd0, NO_PATTERN, NO_PATTERN, FUNC_SERIAL, rcd_pkg::CHAR_CR},
        '{1'b1, 2'd1, OFF_PATTERN, NO_PATTERN, FUNC_SERIAL, rcd_pkg::CHAR_LF}
    };

    relay_channel_command_decoder_core #(
        .LINE_LIMIT(LINE_LIMIT)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stop a hung run
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // Sink: check each relay beat against the oldest one owed, then stall at random
    initial
    begin : relay_sink
        relay_beat_t want;
        int b;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                beats_checked++;
                if (relay_beats_due.size() == 0)
                begin
                    $error("unexpected relay beat: tdata 0x%08h, tlast %0b",
                           m_axis_tdata, m_axis_tlast);
                    mismatches++;
                end
                else
                begin
                    want = relay_beats_due.pop_front();
                    for (b = 0; b < 4; b++)
                    begin
                        if (m_axis_tdata[b*8 +: 8] !== want.pattern[b*8 +: 8])
                        begin
                            $error("%s: expected 0x%02h, actual 0x%02h", byte_field[b],
                                   want.pattern[b*8 +: 8], m_axis_tdata[b*8 +: 8]);
                            mismatches++;
                        end
                    end
                    if (m_axis_tlast !== want.last)
                    begin
                        $error("last_of_run: expected %0b, actual %0b",
                               want.last, m_axis_tlast);
                        mismatches++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Queue the beats an apply of the current channel sends
    function automatic void apply_relays();
        relay_beat_t beat;
        int unsigned idx;
        beat.pattern = OFF_PATTERN;
        beat.last = 1'b1;
        if (channel == rcd_pkg::CH_ALL_OFF)
        begin
            relay_run.push_back(beat);
            return;
        end
        if (channel == '0 || channel > rcd_pkg::CH_MAX_RELAY)
            return;
        beat.last = 1'b0;
        relay_run.push_back(beat);
        // three relays per byte, first byte in the low bits
        idx = channel - 1;
        case (idx % 3)
            0:       beat.pattern[(idx / 3) * 8 +: 8] = rcd_pkg::RELAY_SEL_A;
            1:       beat.pattern[(idx / 3) * 8 +: 8] = rcd_pkg::RELAY_SEL_B;
            default: beat.pattern[(idx / 3) * 8 +: 8] = rcd_pkg::RELAY_SEL_C;
        endcase
        beat.last = 1'b1;
        relay_run.push_back(beat);
    endfunction

    function automatic void take_serial(input logic [7:0] c);
        logic [7:0] prior;
        int unsigned n;
        if (c == rcd_pkg::CHAR_NUL)
            return;
        if (line_len == 0)
            line_head = c;
        else if (line_len == 1)
            line_tail = c;
        prior = last_char;
        last_char = c;
        n = line_len + 1;
        // the byte that reaches the limit wipes the line
        if (n >= LINE_LIMIT)
        begin
            line_len = '0;
            return;
        end
        if (c != rcd_pkg::CHAR_LF)
        begin
            line_len = 4'(n);
            return;
        end
        line_len = '0;
        if (n <= 2 || prior != rcd_pkg::CHAR_CR)
            return;
        if (n == 3 && line_head == rcd_pkg::CHAR_HASH)
            apply_relays();
        else if (n == 3 && line_head == rcd_pkg::CHAR_STAR)
        begin
            channel = rcd_pkg::CH_ALL_OFF;
            apply_relays();
        end
        else if (n == 4 && line_head > rcd_pkg::CHAR_ZERO && line_head <= rcd_pkg::CHAR_NINE)
        begin
            channel = rcd_pkg::CHAN_W'(line_head - rcd_pkg::CHAR_ZERO);
            apply_relays();
        end
        else if (n == 5 && line_tail >= rcd_pkg::CHAR_ZERO && line_tail <= rcd_pkg::CHAR_NINE &&
                 line_head > rcd_pkg::CHAR_ZERO && line_head <= rcd_pkg::CHAR_TWO)
        begin
            channel = rcd_pkg::CHAN_W'((line_head - rcd_pkg::CHAR_ZERO) * 10
                                       + (line_tail - rcd_pkg::CHAR_ZERO));
            if (channel <= rcd_pkg::CH_MAX_RELAY)
                apply_relays();
        end
    endfunction

    function automatic void take_key(input logic [7:0] k);
        if (k == last_key)
            return;
        last_key = k;
        if (k == rcd_pkg::KEY_ALL_OFF)
        begin
            channel = rcd_pkg::CH_ALL_OFF;
            apply_relays();
            return;
        end
        // row in the low three bits, column above; off-table codes keep the channel
        if (k[2:0] <= 3 && k[7:3] <= 5)
            channel = rcd_pkg::CHAN_W'(k[2:0] * 6 + k[7:3] + 1);
        if (channel <= rcd_pkg::CH_MAX_RELAY)
            apply_relays();
    endfunction

    function automatic stim_row_t plain_row(input logic f, input logic [7:0] d);
        stim_row_t row;
        row = '0;
        row.func = f;
        row.data = d;
        return row;
    endfunction

    // Offer one beat, hold it until taken, then book what it owes
    task automatic send_item(input stim_row_t row);
        relay_beat_t beat;
        int k;
        if ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= row.func;
        s_axis_tdata <= row.data;
        do
            @(posedge clk);
        while (!s_axis_tready);
        relay_run.delete();
        if (row.func == FUNC_KEY)
        begin
            take_key(row.data);
            keys_taken++;
            items_taken++;
        end
        else
        begin
            take_serial(row.data);
            serial_taken++;
            if (row.data != rcd_pkg::CHAR_NUL)
                items_taken++;
        end
        if (row.typed)
        begin
            for (k = 0; k < row.n_beats; k++)
            begin
                beat.pattern = (k == 0) ? row.pat0 : row.pat1;
                beat.last = (k == row.n_beats - 1);
                relay_beats_due.push_back(beat);
            end
        end
        else
        begin
            foreach (relay_run[k])
                relay_beats_due.push_back(relay_run[k]);
        end
    endtask

    // Drop valid and hold off until every owed beat has come out
    task automatic drain_relays();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (relay_beats_due.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        stim_row_t burst [$];
        int unsigned pick;
        int unsigned count;
        int unsigned random_start;
        int unsigned next_drain;
        logic [7:0] b;
        int i;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < NUM_DIRECTED; i++)
            send_item(directed_rows[i]);
        drain_relays();

        random_start = items_taken;
        next_drain = items_taken + DRAIN_EVERY;
        while (items_taken - random_start < RANDOM_ITEMS)
        begin
            // one long stretch with neither side idling
            if (items_taken - random_start >= 400 && items_taken - random_start < 560)
                idle_pct = 0;
            else
                idle_pct = IDLE_PCT;

            burst.delete();
            pick = $urandom_range(99);
            if (pick < 45 || (pick >= 70 && pick < 82))
            begin
                // clear any partial line, then a command body
                burst.push_back(plain_row(FUNC_SERIAL, rcd_pkg::CHAR_LF));
                case ($urandom_range(3))
                    0: burst.push_back(plain_row(FUNC_SERIAL, rcd_pkg::CHAR_HASH));
                    1: burst.push_back(plain_row(FUNC_SERIAL, rcd_pkg::CHAR_STAR));
                    2:
                    begin
                        b = 8'($urandom_range(rcd_pkg::CHAR_NINE, rcd_pkg::CHAR_ONE));
                        burst.push_back(plain_row(FUNC_SERIAL, b));
                        b = 8'($urandom_range(255, 1));
                        burst.push_back(plain_row(FUNC_SERIAL,
                                                  (b == rcd_pkg::CHAR_LF) ? rcd_pkg::CHAR_CR : b));
                    end
                    default:
                    begin
                        if ($urandom_range(7) == 0)
                            b = 8'($urandom_range(rcd_pkg::CHAR_NINE, rcd_pkg::CHAR_ZERO));
                        else
                            b = 8'($urandom_range(rcd_pkg::CHAR_TWO, rcd_pkg::CHAR_ONE));
                        burst.push_back(plain_row(FUNC_SERIAL, b));
                        b = 8'($urandom_range(rcd_pkg::CHAR_NINE, rcd_pkg::CHAR_ZERO));
                        burst.push_back(plain_row(FUNC_SERIAL, b));
                        b = 8'($urandom_range(255, 1));
                        burst.push_back(plain_row(FUNC_SERIAL,
                                                  (b == rcd_pkg::CHAR_LF) ? rcd_pkg::CHAR_CR : b));
                    end
                endcase
                if (pick < 45)
                    burst.push_back(plain_row(FUNC_SERIAL, rcd_pkg::CHAR_CR));
                else
                begin
                    // break the ending: missing CR, a stray extra byte, or LF CR
                    case ($urandom_range(2))
                        0: ;
                        1:
                        begin
                            burst.push_back(plain_row(FUNC_SERIAL, 8'($urandom_range(255, 1))));
                            burst.push_back(plain_row(FUNC_SERIAL, rcd_pkg::CHAR_CR));
                        end
                        default:
                        begin
                            burst.push_back(plain_row(FUNC_SERIAL, rcd_pkg::CHAR_LF));
                            burst.push_back(plain_row(FUNC_SERIAL, rcd_pkg::CHAR_CR));
                        end
                    endcase
                end
                burst.push_back(plain_row(FUNC_SERIAL, rcd_pkg::CHAR_LF));
            end
            else if (pick < 70)
            begin
                case ($urandom_range(3))
                    0:
                    begin
                        b[7:3] = 5'($urandom_range(5));
                        b[2:0] = 3'($urandom_range(3));
                    end
                    1: b = rcd_pkg::KEY_ALL_OFF;
                    2: b = last_key;
                    default: b = 8'($urandom_range(255));
                endcase
                burst.push_back(plain_row(FUNC_KEY, b));
            end
            else if (pick < 90)
            begin
                // long line, some ending in CR LF beyond the limit
                burst.push_back(plain_row(FUNC_SERIAL, rcd_pkg::CHAR_LF));
                count = $urandom_range(16, 11);
                repeat (count)
                begin
                    b = 8'($urandom_range(255, 1));
                    burst.push_back(plain_row(FUNC_SERIAL,
                                              (b == rcd_pkg::CHAR_LF) ? rcd_pkg::CHAR_HASH : b));
                end
                burst.push_back(plain_row(FUNC_SERIAL, rcd_pkg::CHAR_CR));
                burst.push_back(plain_row(FUNC_SERIAL, rcd_pkg::CHAR_LF));
            end
            else
            begin
                count = $urandom_range(4, 1);
                repeat (count)
                    burst.push_back(plain_row(1'($urandom_range(1)), 8'($urandom_range(255))));
            end

            foreach (burst[i])
                send_item(burst[i]);
            if (items_taken >= next_drain)
            begin
                drain_relays();
                next_drain = items_taken + DRAIN_EVERY;
            end
        end

        s_axis_tvalid <= 1'b0;
        while (relay_beats_due.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Took %0d serial bytes and %0d keypad codes; compared %0d relay beats.",
                 serial_taken, keys_taken, beats_checked);
        $display("Ran command, broken and overlong lines, table, off-table and repeated keys.");
        if (mismatches == 0 && relay_beats_due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/rcd_pkg.sv
rtl/core/rcd_decode.sv
rtl/core/rcd_emit.sv
rtl/core/relay_channel_command_decoder_core.sv
tb/testbench.sv
